// ===== rtl/lbopc_pkg.sv =====
package lbopc_pkg;

  localparam int unsigned MAX_BOXES  = 64;
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned IDX_W      = $clog2(MAX_BOXES);
  localparam int unsigned CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int unsigned LABEL_W    = 8;
  localparam int unsigned PAIR_W     = 11;
  localparam int unsigned WIRE_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [PAIR_W-1:0]  PAIR_MAX = '1;
  localparam logic [WIRE_W-1:0]  WIRE_MAX = '1;

  localparam logic [LABEL_W-1:0] WIRE_LABEL_RST  = 8'd15;
  localparam logic [PAIR_W-1:0]  TARGET_OVL_RST  = 11'd8;
  localparam logic [WIRE_W-1:0]  TARGET_WIRE_RST = 7'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_WIRE_LABEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_OVL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIRE = 2'd2;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t mid_x;
    coord_t mid_y;
    coord_t ext_x;
    coord_t ext_y;
  } geom_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    geom_t              geom;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             drop;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             commit;
    logic             emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             full;
    logic [CNT_W-1:0] stored;
    logic             busy;
    logic             out_free;
  } status_t;

  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    coord_t r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

  function automatic coord_t mid_of(input coord_t a, input coord_t b);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COORD_BITS:1];
  endfunction

  function automatic geom_t make_geom(input coord_t ax, input coord_t ay,
                                      input coord_t bx, input coord_t by);
    geom_t g;
    g.mid_x = mid_of(ax, bx);
    g.mid_y = mid_of(ay, by);
    g.ext_x = abs_diff(ax, bx);
    g.ext_y = abs_diff(ay, by);
    return g;
  endfunction

  // 2*|ma - mb| <= wa + wb on one axis
  function automatic logic axis_touch(input coord_t ma, input coord_t mb,
                                      input coord_t wa, input coord_t wb);
    logic [COORD_BITS:0] lhs;
    logic [COORD_BITS:0] rhs;
    lhs = {abs_diff(ma, mb), 1'b0};
    rhs = {1'b0, wa} + {1'b0, wb};
    return lhs <= rhs;
  endfunction

endpackage

// ===== rtl/lbopc_ctrl.sv =====
module lbopc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                final_box_i,
  input  lbopc_pkg::status_t  status_i,
  output lbopc_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e                          state_q, state_d;
  logic [lbopc_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic                            last_q, last_d;
  logic                            accept;
  logic                            scan_done;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign scan_done  = (lbopc_pkg::CNT_W'(idx_q) == status_i.stored);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    last_d        = last_q;
    cmd_o         = '0;
    cmd_o.rd_idx  = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d = final_box_i;
          idx_d  = '0;
          if (status_i.full) begin
            cmd_o.drop = 1'b1;
            state_d    = final_box_i ? ST_EMIT : ST_IDLE;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.rd_en = 1'b1;
          idx_d       = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // wait for the last compare to land in the tally
        if (!status_i.busy) begin
          cmd_o.commit = 1'b1;
          state_d      = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

endmodule

// ===== rtl/lbopc_dp.sv =====
module lbopc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lbopc_pkg::cmd_t                     cmd_i,
  output lbopc_pkg::status_t                  status_o,
  input  logic                                cfg_we_i,
  input  logic [lbopc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lbopc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [lbopc_pkg::LABEL_W-1:0]       class_label_i,
  input  lbopc_pkg::coord_t                   corner_a_x_i,
  input  lbopc_pkg::coord_t                   corner_a_y_i,
  input  lbopc_pkg::coord_t                   corner_b_x_i,
  input  lbopc_pkg::coord_t                   corner_b_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lbopc_pkg::PAIR_W-1:0]        overlap_pairs_o,
  output logic [lbopc_pkg::WIRE_W-1:0]        wire_total_o,
  output logic                                loop_formed_o,
  output logic [lbopc_pkg::PAIR_W-1:0]        reported_value_o,
  output logic                                capacity_exceeded_o
);

  // configuration
  logic [lbopc_pkg::LABEL_W-1:0] wire_label_q;
  logic [lbopc_pkg::PAIR_W-1:0]  target_ovl_q;
  logic [lbopc_pkg::WIRE_W-1:0]  target_wire_q;

  // box store
  lbopc_pkg::entry_t             store_mem [lbopc_pkg::MAX_BOXES];
  lbopc_pkg::entry_t             rd_data_q;
  logic                          rd_vld_q;

  // box under test
  lbopc_pkg::entry_t             new_q;
  logic                          new_wire_q;

  // set tallies
  logic [lbopc_pkg::CNT_W-1:0]   stored_q;
  logic [lbopc_pkg::PAIR_W-1:0]  pair_q;
  logic [lbopc_pkg::WIRE_W-1:0]  wire_q;
  logic                          dropped_q;
  logic                          hit_q, hit_d;

  // result register
  logic                          out_valid_q;
  logic [lbopc_pkg::PAIR_W-1:0]  out_pairs_q;
  logic [lbopc_pkg::WIRE_W-1:0]  out_wire_q;
  logic                          out_formed_q;
  logic                          out_dropped_q;
  logic                          formed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wire_label_q  <= lbopc_pkg::WIRE_LABEL_RST;
      target_ovl_q  <= lbopc_pkg::TARGET_OVL_RST;
      target_wire_q <= lbopc_pkg::TARGET_WIRE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lbopc_pkg::CFG_WIRE_LABEL:  wire_label_q  <= cfg_data_i[lbopc_pkg::LABEL_W-1:0];
        lbopc_pkg::CFG_TARGET_OVL:  target_ovl_q  <= cfg_data_i[lbopc_pkg::PAIR_W-1:0];
        lbopc_pkg::CFG_TARGET_WIRE: target_wire_q <= cfg_data_i[lbopc_pkg::WIRE_W-1:0];
        default: ;
      endcase
    end
  end

  // new box: geometry is worked out once on the way in
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      new_q.label <= class_label_i;
      new_q.geom  <= lbopc_pkg::make_geom(corner_a_x_i, corner_a_y_i,
                                          corner_b_x_i, corner_b_y_i);
      new_wire_q  <= (class_label_i == wire_label_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      store_mem[stored_q[lbopc_pkg::IDX_W-1:0]] <= new_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= store_mem[cmd_i.rd_idx];
    end
  end

  always_comb begin
    hit_d = rd_vld_q
         && (new_wire_q != (rd_data_q.label == wire_label_q))
         && lbopc_pkg::axis_touch(new_q.geom.mid_x, rd_data_q.geom.mid_x,
                                  new_q.geom.ext_x, rd_data_q.geom.ext_x)
         && lbopc_pkg::axis_touch(new_q.geom.mid_y, rd_data_q.geom.mid_y,
                                  new_q.geom.ext_y, rd_data_q.geom.ext_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      stored_q  <= '0;
      pair_q    <= '0;
      wire_q    <= '0;
      dropped_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      hit_q    <= hit_d;
      if (cmd_i.emit) begin
        stored_q  <= '0;
        pair_q    <= '0;
        wire_q    <= '0;
        dropped_q <= 1'b0;
      end else begin
        if (hit_q && (pair_q != lbopc_pkg::PAIR_MAX)) begin
          pair_q <= pair_q + 1'b1;
        end
        if (cmd_i.commit) begin
          stored_q <= stored_q + 1'b1;
          if (new_wire_q && (wire_q != lbopc_pkg::WIRE_MAX)) begin
            wire_q <= wire_q + 1'b1;
          end
        end
        if (cmd_i.drop) begin
          dropped_q <= 1'b1;
        end
      end
    end
  end

  assign formed = (pair_q == target_ovl_q) && (wire_q == target_wire_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pairs_q   <= pair_q;
      out_wire_q    <= wire_q;
      out_formed_q  <= formed;
      out_dropped_q <= dropped_q;
    end
  end

  assign status_o.full     = (stored_q == lbopc_pkg::CNT_W'(lbopc_pkg::MAX_BOXES));
  assign status_o.stored   = stored_q;
  assign status_o.busy     = rd_vld_q || hit_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o         = out_valid_q;
  assign overlap_pairs_o     = out_pairs_q;
  assign wire_total_o        = out_wire_q;
  assign loop_formed_o       = out_formed_q;
  assign reported_value_o    = out_formed_q ? out_pairs_q : '0;
  assign capacity_exceeded_o = out_dropped_q;

endmodule

// ===== rtl/labeled_box_overlap_pair_counter.sv =====
// Counts overlapping pairs of boxes in a set where exactly one box of the pair
// carries the wire label. Boxes arrive one per transaction; the transaction
// with final_box_i set closes the set and yields one result transaction, after
// which the tallies clear for the next set. Each accepted box is compared with
// every box already stored, one stored box per cycle through the box store,
// and holds the input until that scan and the tally update are done; at most
// 63 boxes can already be in the set, with a 64-entry store. The box that
// closes the set also holds the input while the result register is loaded,
// and longer while an earlier result is still stalled there. A box arriving
// when the store is full is dropped and reported through capacity_exceeded_o.
// The input may be taken while a finished result still waits at the output.
module labeled_box_overlap_pair_counter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lbopc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lbopc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lbopc_pkg::LABEL_W-1:0]       class_label_i,
  input  lbopc_pkg::coord_t                   corner_a_x_i,
  input  lbopc_pkg::coord_t                   corner_a_y_i,
  input  lbopc_pkg::coord_t                   corner_b_x_i,
  input  lbopc_pkg::coord_t                   corner_b_y_i,
  input  logic                                final_box_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lbopc_pkg::PAIR_W-1:0]        overlap_pairs_o,
  output logic [lbopc_pkg::WIRE_W-1:0]        wire_total_o,
  output logic                                loop_formed_o,
  output logic [lbopc_pkg::PAIR_W-1:0]        reported_value_o,
  output logic                                capacity_exceeded_o
);

  lbopc_pkg::cmd_t    cmd;
  lbopc_pkg::status_t status;

  lbopc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .final_box_i (final_box_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lbopc_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .class_label_i       (class_label_i),
    .corner_a_x_i        (corner_a_x_i),
    .corner_a_y_i        (corner_a_y_i),
    .corner_b_x_i        (corner_b_x_i),
    .corner_b_y_i        (corner_b_y_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .overlap_pairs_o     (overlap_pairs_o),
    .wire_total_o        (wire_total_o),
    .loop_formed_o       (loop_formed_o),
    .reported_value_o    (reported_value_o),
    .capacity_exceeded_o (capacity_exceeded_o)
  );

endmodule

// ===== bench/overlap_tally_checker.sv =====
module overlap_tally_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lbopc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lbopc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [lbopc_pkg::LABEL_W-1:0]    class_label_i,
  input  lbopc_pkg::coord_t                corner_a_x_i,
  input  lbopc_pkg::coord_t                corner_a_y_i,
  input  lbopc_pkg::coord_t                corner_b_x_i,
  input  lbopc_pkg::coord_t                corner_b_y_i,
  input  logic                             final_box_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [lbopc_pkg::PAIR_W-1:0]     overlap_pairs_i,
  input  logic [lbopc_pkg::WIRE_W-1:0]     wire_total_i,
  input  logic                             loop_formed_i,
  input  logic [lbopc_pkg::PAIR_W-1:0]     reported_value_i,
  input  logic                             capacity_exceeded_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               results_o,
  output int                               formed_o,
  output int                               dropped_o
);
  import lbopc_pkg::*;

  localparam int PAIR_CAP = 2047;
  localparam int WIRE_CAP = 127;

  typedef struct packed {
    coord_t mx;
    coord_t my;
    coord_t wx;
    coord_t wy;
  } shape_t;

  typedef struct packed {
    logic [PAIR_W-1:0] pairs;
    logic [WIRE_W-1:0] wires;
    logic              formed;
    logic [PAIR_W-1:0] shown;
    logic              spilled;
  } tally_t;

  logic [LABEL_W-1:0] wire_lbl;
  logic [PAIR_W-1:0]  want_pairs;
  logic [WIRE_W-1:0]  want_wires;

  logic [LABEL_W-1:0] lbl_mem [MAX_BOXES];
  shape_t             shape_mem [MAX_BOXES];
  int                 held;
  int                 pair_cnt;
  int                 wire_cnt;
  bit                 spilled;

  tally_t due_results [$];
  int     mismatches;
  int     waiting;
  int     results;
  int     formed_sets;
  int     dropped_sets;

  assign fail_count_o = mismatches + waiting;
  assign pending_o    = waiting;
  assign results_o    = results;
  assign formed_o     = formed_sets;
  assign dropped_o    = dropped_sets;

  function automatic shape_t shape_of(input coord_t ax, input coord_t ay,
                                      input coord_t bx, input coord_t by);
    shape_t s;
    int     d;
    s.mx = coord_t'((int'(ax) + int'(bx)) >> 1);
    s.my = coord_t'((int'(ay) + int'(by)) >> 1);
    d = int'(ax) - int'(bx);
    s.wx = coord_t'((d < 0) ? -d : d);
    d = int'(ay) - int'(by);
    s.wy = coord_t'((d < 0) ? -d : d);
    return s;
  endfunction

  function automatic bit shapes_meet(input shape_t p, input shape_t q);
    int dx;
    int dy;
    dx = int'(p.mx) - int'(q.mx);
    dy = int'(p.my) - int'(q.my);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (2 * dx <= int'(p.wx) + int'(q.wx)) && (2 * dy <= int'(p.wy) + int'(q.wy));
  endfunction

  task fold_in_box();
    shape_t s;
    bit     is_wire;
    tally_t r;
    s = shape_of(corner_a_x_i, corner_a_y_i, corner_b_x_i, corner_b_y_i);
    is_wire = (class_label_i == wire_lbl);
    if (held < MAX_BOXES) begin
      // labels of stored boxes are judged against the label register as it stands now
      for (int i = 0; i < held; i++) begin
        if (is_wire != (lbl_mem[i] == wire_lbl) && shapes_meet(s, shape_mem[i])) begin
          if (pair_cnt < PAIR_CAP) pair_cnt++;
        end
      end
      if (is_wire && wire_cnt < WIRE_CAP) wire_cnt++;
      lbl_mem[held]   = class_label_i;
      shape_mem[held] = s;
      held++;
    end else begin
      spilled = 1'b1;
    end
    if (final_box_i) begin
      r.pairs   = pair_cnt[PAIR_W-1:0];
      r.wires   = wire_cnt[WIRE_W-1:0];
      r.formed  = (r.pairs == want_pairs) && (r.wires == want_wires);
      r.shown   = r.formed ? r.pairs : '0;
      r.spilled = spilled;
      due_results.push_back(r);
      waiting++;
      held     = 0;
      pair_cnt = 0;
      wire_cnt = 0;
      spilled  = 1'b0;
    end
  endtask

  task check_result();
    tally_t e;
    if (waiting == 0) begin
      if (mismatches < 10) begin
        $display("%0t: unexpected result pairs=%0d wires=%0d formed=%0b value=%0d dropped=%0b",
                 $time, overlap_pairs_i, wire_total_i, loop_formed_i, reported_value_i,
                 capacity_exceeded_i);
      end
      mismatches++;
    end else begin
      e = due_results.pop_front();
      waiting--;
      results++;
      if (e.formed) formed_sets++;
      if (e.spilled) dropped_sets++;
      if (overlap_pairs_i !== e.pairs || wire_total_i !== e.wires ||
          loop_formed_i !== e.formed || reported_value_i !== e.shown ||
          capacity_exceeded_i !== e.spilled) begin
        if (mismatches < 10) begin
          $display("%0t: expected pairs=%0d wires=%0d formed=%0b value=%0d dropped=%0b",
                   $time, e.pairs, e.wires, e.formed, e.shown, e.spilled);
          $display("%0t:      got pairs=%0d wires=%0d formed=%0b value=%0d dropped=%0b",
                   $time, overlap_pairs_i, wire_total_i, loop_formed_i, reported_value_i,
                   capacity_exceeded_i);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wire_lbl     = WIRE_LABEL_RST;
      want_pairs   = TARGET_OVL_RST;
      want_wires   = TARGET_WIRE_RST;
      held         = 0;
      pair_cnt     = 0;
      wire_cnt     = 0;
      spilled      = 1'b0;
      mismatches   = 0;
      waiting      = 0;
      results      = 0;
      formed_sets  = 0;
      dropped_sets = 0;
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIRE_LABEL:  wire_lbl   = cfg_data_i[LABEL_W-1:0];
          CFG_TARGET_OVL:  want_pairs = cfg_data_i[PAIR_W-1:0];
          CFG_TARGET_WIRE: want_wires = cfg_data_i[WIRE_W-1:0];
          default: ;
        endcase
      end
      // compare first so a result can never consume an expectation pushed this cycle
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) fold_in_box();
    end
  end

endmodule

// ===== bench/tb_labeled_box_overlap_pair_counter.sv =====
module tb_labeled_box_overlap_pair_counter;
  import lbopc_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_BOXES  = 240;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [LABEL_W-1:0]    class_label_i;
  coord_t                corner_a_x_i;
  coord_t                corner_a_y_i;
  coord_t                corner_b_x_i;
  coord_t                corner_b_y_i;
  logic                  final_box_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [PAIR_W-1:0]     overlap_pairs_o;
  logic [WIRE_W-1:0]     wire_total_o;
  logic                  loop_formed_o;
  logic [PAIR_W-1:0]     reported_value_o;
  logic                  capacity_exceeded_o;

  int fail_count;
  int pending;
  int results;
  int formed_sets;
  int dropped_sets;

  bit                 quiet;
  bit                 hold_now;
  logic [LABEL_W-1:0] cur_wire;
  int                 boxes_sent;
  int                 sets_sent;
  int                 idle_cycles;

  labeled_box_overlap_pair_counter dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .class_label_i       (class_label_i),
    .corner_a_x_i        (corner_a_x_i),
    .corner_a_y_i        (corner_a_y_i),
    .corner_b_x_i        (corner_b_x_i),
    .corner_b_y_i        (corner_b_y_i),
    .final_box_i         (final_box_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .overlap_pairs_o     (overlap_pairs_o),
    .wire_total_o        (wire_total_o),
    .loop_formed_o       (loop_formed_o),
    .reported_value_o    (reported_value_o),
    .capacity_exceeded_o (capacity_exceeded_o)
  );

  overlap_tally_checker checker_i (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .class_label_i       (class_label_i),
    .corner_a_x_i        (corner_a_x_i),
    .corner_a_y_i        (corner_a_y_i),
    .corner_b_x_i        (corner_b_x_i),
    .corner_b_y_i        (corner_b_y_i),
    .final_box_i         (final_box_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .overlap_pairs_i     (overlap_pairs_o),
    .wire_total_i        (wire_total_o),
    .loop_formed_i       (loop_formed_o),
    .reported_value_i    (reported_value_o),
    .capacity_exceeded_i (capacity_exceeded_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .results_o           (results),
    .formed_o            (formed_sets),
    .dropped_o           (dropped_sets)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[labeled_box_overlap_pair_counter] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall, or a long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_now) begin
        hold_now = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 6);
      end
    end
  end

  task send_box(input logic [LABEL_W-1:0] lbl, input coord_t ax, input coord_t ay,
                input coord_t bx, input coord_t by, input logic fin);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    class_label_i <= lbl;
    corner_a_x_i  <= ax;
    corner_a_y_i  <= ay;
    corner_b_x_i  <= bx;
    corner_b_y_i  <= by;
    final_box_i   <= fin;
    do @(posedge clk_i); while (in_stall_o);
    boxes_sent++;
    if (fin) sets_sent++;
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    if (idx == CFG_WIRE_LABEL) cur_wire = LABEL_W'(val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // let every expected result arrive, then let any box still in flight finish
  task quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [LABEL_W-1:0] pick_label();
    int r;
    r = $urandom_range(99);
    if (r < 45) return cur_wire;
    if (r < 65) return cur_wire ^ 8'h01;
    return LABEL_W'($urandom);
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(6, 1);
    if (r < 92) return $urandom_range(20, 7);
    if (r < 98) return $urandom_range(64, 21);
    return $urandom_range(70, 65);
  endfunction

  // mostly clustered boxes so that overlaps are common, some spread at random
  task send_set(input int n);
    int     mode;
    int     ox;
    int     oy;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    mode = $urandom_range(99);
    ox = $urandom_range(3968);
    oy = $urandom_range(3968);
    if (mode >= 75 && mode < 85) begin
      ox = $urandom_range(1) * 3968;
      oy = $urandom_range(1) * 3968;
    end
    for (int k = 0; k < n; k++) begin
      if (mode >= 85) begin
        ax = coord_t'($urandom);
        ay = coord_t'($urandom);
        bx = coord_t'($urandom);
        by = coord_t'($urandom);
      end else begin
        ax = coord_t'(ox + $urandom_range(127));
        ay = coord_t'(oy + $urandom_range(127));
        bx = coord_t'(ox + $urandom_range(127));
        by = coord_t'(oy + $urandom_range(127));
      end
      send_box(pick_label(), ax, ay, bx, by, k == n - 1);
    end
  endtask

  initial begin
    int phase_boxes;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_WIRE_LABEL;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    class_label_i = '0;
    corner_a_x_i  = '0;
    corner_a_y_i  = '0;
    corner_b_x_i  = '0;
    corner_b_y_i  = '0;
    final_box_i   = 1'b0;
    quiet         = 1'b0;
    hold_now      = 1'b0;
    cur_wire      = WIRE_LABEL_RST;
    boxes_sent    = 0;
    sets_sent     = 0;
    idle_cycles   = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // four wires and two others stacked on one spot: 8 pairs, formed under reset targets
    send_box(8'd15, 12'd100, 12'd200, 12'd300, 12'd400, 1'b0);
    send_box(8'd3,  12'd300, 12'd400, 12'd100, 12'd200, 1'b0);
    send_box(8'd15, 12'd100, 12'd400, 12'd300, 12'd200, 1'b0);
    send_box(8'd15, 12'd300, 12'd200, 12'd100, 12'd400, 1'b0);
    send_box(8'd3,  12'd100, 12'd200, 12'd300, 12'd400, 1'b0);
    send_box(8'd15, 12'd100, 12'd200, 12'd300, 12'd400, 1'b1);
    // single-box sets at the coordinate extremes
    send_box(8'd255, 12'd4095, 12'd4095, 12'd0, 12'd0, 1'b1);
    send_box(8'd0,   12'd0,    12'd0,    12'd0, 12'd0, 1'b1);
    // touching exactly at the edge, one step apart, far away, truncated midpoint
    send_box(8'd15,  12'd0,    12'd0,    12'd10,   12'd10,   1'b0);
    send_box(8'd3,   12'd20,   12'd0,    12'd10,   12'd10,   1'b0);
    send_box(8'd3,   12'd11,   12'd0,    12'd21,   12'd10,   1'b0);
    send_box(8'd15,  12'd4095, 12'd4095, 12'd4085, 12'd4085, 1'b0);
    send_box(8'd3,   12'd3,    12'd5,    12'd0,    12'd2,    1'b1);
    // label changed mid-set: the stored box turns into a wire for the next comparison
    send_box(8'd7,  12'd100, 12'd100, 12'd110, 12'd110, 1'b0);
    quiesce();
    write_reg(CFG_WIRE_LABEL, 7);
    send_box(8'd15, 12'd100, 12'd100, 12'd110, 12'd110, 1'b1);

    for (int p = 0; p < 8; p++) begin
      quiesce();
      case (p)
        0: begin
          write_reg(CFG_WIRE_LABEL, 15);
          write_reg(CFG_TARGET_OVL, 8);
          write_reg(CFG_TARGET_WIRE, 4);
        end
        1: begin
          write_reg(CFG_WIRE_LABEL, 0);
          write_reg(CFG_TARGET_OVL, 0);
          write_reg(CFG_TARGET_WIRE, 0);
        end
        2: begin
          write_reg(CFG_WIRE_LABEL, 255);
          write_reg(CFG_TARGET_OVL, 2016);
          write_reg(CFG_TARGET_WIRE, 64);
        end
        3: begin
          write_reg(CFG_WIRE_LABEL, $urandom_range(255));
          write_reg(CFG_TARGET_OVL, 1);
          write_reg(CFG_TARGET_WIRE, 1);
        end
        4: begin
          write_reg(CFG_WIRE_LABEL, $urandom_range(255));
          write_reg(CFG_TARGET_OVL, 2);
          write_reg(CFG_TARGET_WIRE, 1);
        end
        5: begin
          write_reg(CFG_WIRE_LABEL, 255);
          write_reg(CFG_TARGET_OVL, 0);
          write_reg(CFG_TARGET_WIRE, 0);
        end
        6: begin
          write_reg(CFG_WIRE_LABEL, 0);
          write_reg(CFG_TARGET_OVL, $urandom_range(2016));
          write_reg(CFG_TARGET_WIRE, $urandom_range(64));
        end
        default: begin
          write_reg(CFG_WIRE_LABEL, $urandom_range(255));
          write_reg(CFG_TARGET_OVL, 0);
          write_reg(CFG_TARGET_WIRE, 1);
        end
      endcase
      quiet = (p == 2);
      phase_boxes = 0;
      if (p == 0) begin
        // a full store, then one that spills over
        send_set(64);
        send_set(66);
        phase_boxes = 130;
      end
      if (p == 3) begin
        // receiver holds off while small sets keep coming until the input backs up
        hold_now = 1'b1;
        for (int k = 0; k < 12; k++) begin
          send_set($urandom_range(2, 1));
        end
      end
      while (phase_boxes < PHASE_BOXES) begin
        int n;
        n = pick_size();
        send_set(n);
        phase_boxes += n;
      end
      quiet = 1'b0;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES + 20) @(posedge clk_i);
    $display("sent %0d boxes in %0d sets across eight register settings and directed cases",
             boxes_sent, sets_sent);
    $display("checked %0d results: %0d with the loop formed, %0d with boxes dropped",
             results, formed_sets, dropped_sets);
    if (fail_count == 0) begin
      $display("[labeled_box_overlap_pair_counter] OK");
    end else begin
      $display("[labeled_box_overlap_pair_counter] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lbopc_pkg.sv
rtl/lbopc_ctrl.sv
rtl/lbopc_dp.sv
rtl/labeled_box_overlap_pair_counter.sv
bench/overlap_tally_checker.sv
bench/tb_labeled_box_overlap_pair_counter.sv
